>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the alignment snap RTL.
// Needs signals named clk and rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASN_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/asnap_pkg.sv
// Types, constants and helpers of the alignment snap search block.
// No dependencies.
package asnap_pkg;

  localparam int MAX_RECTS_DEF   = 16;
  localparam int GUIDE_LIMIT_DEF = 63;
  localparam int AW    = 28;   // internal signed arithmetic width
  localparam int CRDW  = 20;   // input coordinate width
  localparam int SZW   = 19;   // input size width
  localparam int GCW   = 21;   // guide_coord width
  localparam int OW    = 22;   // out_a / out_b width
  localparam int THRW  = 16;
  localparam int BW    = 17;   // best-distance register width
  localparam int CFGW  = 16;
  localparam int CFGIW = 1;
  localparam logic [THRW-1:0] THR_RESET = 16'd320;
  localparam logic [AW-1:0] GUIDE_TOL = 28'd32;   // half pixel in 1/64 units
  localparam logic [AW-1:0] THR_PAD   = 28'd32;

  localparam logic [CFGIW-1:0] REG_ENABLE    = 1'd0;
  localparam logic [CFGIW-1:0] REG_THRESHOLD = 1'd1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_MOVE   = 2'd2,
    OP_RESIZE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SNAP,
    ST_GDX,
    ST_GDY,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    GT_LEFT    = 3'd0,
    GT_RIGHT   = 3'd1,
    GT_HCENTRE = 3'd2,
    GT_TOP     = 3'd3,
    GT_BOTTOM  = 3'd4,
    GT_VCENTRE = 3'd5
  } guide_t;

  typedef struct packed {
    logic       start;
    logic       wr;
    logic       srch;
    logic       snap;
    logic       gload;
    logic       gdrop;
    logic       fin;
    logic       axis;
    logic [1:0] p;
    logic [1:0] k;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic out_free;
    logic glim;
    logic xs;
    logic ys;
    logic enable;
  } dp_stat_t;

  function automatic logic [AW-1:0] abs_diff(input logic signed [AW-1:0] a,
                                             input logic signed [AW-1:0] b);
    logic signed [AW-1:0] d;
    d = a - b;
    return d[AW-1] ? AW'(-d) : AW'(d);
  endfunction

  function automatic logic [GCW-1:0] sat_gc(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    hi = AW'((1 << (GCW - 1)) - 1);
    lo = -hi - AW'(1);
    if (v > hi) return hi[GCW-1:0];
    else if (v < lo) return lo[GCW-1:0];
    else return v[GCW-1:0];
  endfunction

  function automatic logic [OW-1:0] sat_out(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    hi = AW'((1 << (OW - 1)) - 1);
    lo = -hi - AW'(1);
    if (v > hi) return hi[OW-1:0];
    else if (v < lo) return lo[OW-1:0];
    else return v[OW-1:0];
  endfunction

endpackage

>>> hw/rtl/asnap_if.sv
// Channel interfaces of the alignment snap search block.
// Depends on asnap_pkg for field widths.
interface asnap_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          operation;
  logic signed [asnap_pkg::CRDW-1:0]   rect_x;
  logic signed [asnap_pkg::CRDW-1:0]   rect_y;
  logic [asnap_pkg::SZW-1:0]           rect_w;
  logic [asnap_pkg::SZW-1:0]           rect_h;
  modport source (output valid, operation, rect_x, rect_y, rect_w, rect_h, input ready);
  modport sink (input valid, operation, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

interface asnap_out_if;
  logic                              valid;
  logic                              ready;
  logic                              item_kind;
  logic [2:0]                        guide_type;
  logic signed [asnap_pkg::GCW-1:0]  guide_coord;
  logic signed [asnap_pkg::OW-1:0]   out_a;
  logic signed [asnap_pkg::OW-1:0]   out_b;
  logic                              x_snapped;
  logic                              y_snapped;
  logic                              guides_dropped;
  logic                              table_full;
  logic                              last;
  modport source (output valid, item_kind, guide_type, guide_coord, out_a, out_b,
                  x_snapped, y_snapped, guides_dropped, table_full, last, input ready);
  modport sink (input valid, item_kind, guide_type, guide_coord, out_a, out_b,
                x_snapped, y_snapped, guides_dropped, table_full, last, output ready);
endinterface

>>> hw/rtl/asnap_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module asnap_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                 wdata,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                 rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/asnap_ctrl.sv
// Sequencer of the alignment snap search: table count and scan counters.
// Depends on asnap_pkg and assert_macros.svh.
`include "assert_macros.svh"
module asnap_ctrl #(
  parameter int MAX_RECTS = asnap_pkg::MAX_RECTS_DEF,
  localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1,
  localparam int CW = $clog2(MAX_RECTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           in_op,
  output logic                 in_ready,
  input  asnap_pkg::dp_stat_t  stat,
  output asnap_pkg::ctrl_cmd_t cmd,
  output logic [IW-1:0]        rd_addr,
  output logic [IW-1:0]        wr_addr
);
  asnap_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] i, i_next;
  logic [1:0]    p, p_next, k, k_next;
  logic          last_i;
  logic          axis_on;
  asnap_pkg::op_t op;

  assign op      = asnap_pkg::op_t'(in_op);
  assign last_i  = (CW'(i) + CW'(1)) == count;
  assign rd_addr = i_next;
  assign wr_addr = count[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asnap_pkg::ST_IDLE;
      count <= '0;
      i     <= '0;
      p     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      i     <= i_next;
      p     <= p_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    i_next     = i;
    p_next     = p;
    k_next     = k;
    cmd        = '0;
    cmd.p      = p;
    cmd.k      = k;
    cmd.axis   = (state == asnap_pkg::ST_GDY);
    in_ready   = (state == asnap_pkg::ST_IDLE);
    axis_on    = (state == asnap_pkg::ST_GDY) ? stat.ys : stat.xs;
    unique case (state)
      asnap_pkg::ST_IDLE: begin
        i_next = '0;
        p_next = '0;
        k_next = '0;
        if (in_valid) begin
          cmd.start = 1'b1;
          unique case (op)
            asnap_pkg::OP_CLEAR: begin
              count_next = '0;
              state_next = asnap_pkg::ST_FIN;
            end
            asnap_pkg::OP_ADD: begin
              if (count < CW'(MAX_RECTS)) begin
                cmd.wr     = 1'b1;
                count_next = count + CW'(1);
              end
              state_next = asnap_pkg::ST_FIN;
            end
            asnap_pkg::OP_MOVE, asnap_pkg::OP_RESIZE: begin
              if (!stat.enable) state_next = asnap_pkg::ST_FIN;
              else if (count == '0) state_next = asnap_pkg::ST_SNAP;
              else begin
                state_next = asnap_pkg::ST_SRCH;
                // resize has no left-edge point
                p_next = (op == asnap_pkg::OP_MOVE) ? 2'd0 : 2'd1;
              end
            end
          endcase
        end
      end
      asnap_pkg::ST_SRCH: begin
        cmd.srch = 1'b1;
        if (!last_i) i_next = i + IW'(1);
        else begin
          i_next = '0;
          if (k != 2'd2) k_next = k + 2'd1;
          else begin
            k_next = '0;
            if (p != 2'd2) p_next = p + 2'd1;
            else begin
              p_next     = '0;
              state_next = asnap_pkg::ST_SNAP;
            end
          end
        end
      end
      asnap_pkg::ST_SNAP: begin
        cmd.snap   = 1'b1;
        state_next = asnap_pkg::ST_GDX;
      end
      asnap_pkg::ST_GDX, asnap_pkg::ST_GDY: begin
        if (!axis_on || count == '0) begin
          state_next = (state == asnap_pkg::ST_GDX) ? asnap_pkg::ST_GDY : asnap_pkg::ST_FIN;
        end else if (!(stat.hit && !stat.glim && !stat.out_free)) begin
          cmd.gload = stat.hit && !stat.glim;
          cmd.gdrop = stat.hit && stat.glim;
          // point innermost, then entry, then candidate kind
          if (p != 2'd2) p_next = p + 2'd1;
          else begin
            p_next = '0;
            if (!last_i) i_next = i + IW'(1);
            else begin
              i_next = '0;
              if (k != 2'd2) k_next = k + 2'd1;
              else begin
                k_next     = '0;
                state_next = (state == asnap_pkg::ST_GDX) ? asnap_pkg::ST_GDY
                                                          : asnap_pkg::ST_FIN;
              end
            end
          end
        end
      end
      asnap_pkg::ST_FIN: begin
        if (stat.out_free) begin
          cmd.fin    = 1'b1;
          state_next = asnap_pkg::ST_IDLE;
        end
      end
      default: state_next = asnap_pkg::ST_IDLE;
    endcase
  end

  `ASN_ASSERT(a_count_range, count <= CW'(MAX_RECTS))
  `ASN_ASSERT_NEXT(a_fin_to_idle, cmd.fin, state == asnap_pkg::ST_IDLE)
  `ASN_ASSERT(a_gload_room, !cmd.gload || stat.out_free)
endmodule

>>> hw/rtl/asnap_dp.sv
// Datapath: rectangle table, nearest-match registers, guide test, output register.
// Depends on asnap_pkg, asnap_ram, asnap_if and assert_macros.svh.
`include "assert_macros.svh"
module asnap_dp #(
  parameter int MAX_RECTS   = asnap_pkg::MAX_RECTS_DEF,
  parameter int GUIDE_LIMIT = asnap_pkg::GUIDE_LIMIT_DEF,
  localparam int IW  = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1,
  localparam int GLW = $clog2(GUIDE_LIMIT + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  asnap_pkg::ctrl_cmd_t              cmd,
  output asnap_pkg::dp_stat_t               stat,
  input  logic [1:0]                        in_op,
  input  logic signed [asnap_pkg::CRDW-1:0] in_x,
  input  logic signed [asnap_pkg::CRDW-1:0] in_y,
  input  logic [asnap_pkg::SZW-1:0]         in_w,
  input  logic [asnap_pkg::SZW-1:0]         in_h,
  input  logic [IW-1:0]                     rd_addr,
  input  logic [IW-1:0]                     wr_addr,
  input  logic                              cfg_we,
  input  logic [asnap_pkg::CFGIW-1:0]       cfg_index,
  input  logic [asnap_pkg::CFGW-1:0]        cfg_data,
  asnap_out_if.source                       out_ch
);
  localparam int AW = asnap_pkg::AW;
  localparam int EW = 2 * asnap_pkg::CRDW + 2 * asnap_pkg::SZW;

  logic [EW-1:0] rdata;
  logic signed [AW-1:0] el2, et2, ew, eh;
  logic signed [AW-1:0] cx, cy, cand, gpt, gc2;
  logic [AW-1:0] dx, dy, dg;

  logic enable;
  logic [asnap_pkg::THRW-1:0] thr;
  asnap_pkg::op_t op;
  logic signed [AW-1:0] x2, y2, w1, h1;
  logic signed [AW-1:0] px [3];
  logic signed [AW-1:0] py [3];
  logic signed [AW-1:0] gpx [3];
  logic signed [AW-1:0] gpy [3];
  logic [asnap_pkg::BW-1:0] bestx, besty;
  logic signed [AW-1:0] bx, by;
  logic [1:0] tx, ty;
  logic xs, ys, dropped;
  logic [GLW-1:0] gcnt;
  logic signed [AW-1:0] fa, fb;
  logic full_at_add;

  logic signed [AW-1:0] ix2, iy2, iw, ih;
  logic signed [AW-1:0] lx, ty0, ax, bh, tdx, tdy;
  logic xs_n, ys_n;

  asnap_ram #(.W(EW), .D(MAX_RECTS)) u_tab (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (wr_addr),
    .wdata ({in_x, in_y, in_w, in_h}),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // candidates of the entry at the current scan index, in 1/32 px
  assign el2 = AW'(signed'(rdata[EW-1 -: asnap_pkg::CRDW])) <<< 1;
  assign et2 = AW'(signed'(rdata[EW-asnap_pkg::CRDW-1 -: asnap_pkg::CRDW])) <<< 1;
  assign ew  = AW'(rdata[2*asnap_pkg::SZW-1 -: asnap_pkg::SZW]);
  assign eh  = AW'(rdata[asnap_pkg::SZW-1:0]);

  always_comb begin
    unique case (cmd.k)
      2'd0:    begin cx = el2;                cy = et2; end
      2'd1:    begin cx = el2 + (ew <<< 1);   cy = et2 + (eh <<< 1); end
      default: begin cx = el2 + ew;           cy = et2 + eh; end
    endcase
  end

  assign dx = asnap_pkg::abs_diff(px[cmd.p], cx);
  assign dy = asnap_pkg::abs_diff(py[cmd.p], cy);

  // guide test in 1/64 px
  assign cand = cmd.axis ? cy : cx;
  assign gpt  = cmd.axis ? gpy[cmd.p] : gpx[cmd.p];
  assign gc2  = cand <<< 1;
  assign dg   = asnap_pkg::abs_diff(gpt, gc2);

  assign ix2 = AW'(in_x) <<< 1;
  assign iy2 = AW'(in_y) <<< 1;
  assign iw  = AW'(in_w);
  assign ih  = AW'(in_h);

  // snap resolution
  always_comb begin
    xs_n = ({{(AW-asnap_pkg::BW){1'b0}}, bestx} <= AW'(thr));
    ys_n = ({{(AW-asnap_pkg::BW){1'b0}}, besty} <= AW'(thr));
    lx   = bx - ((tx == 2'd0) ? AW'(0) : (tx == 2'd1) ? (w1 <<< 1) : w1);
    ty0  = by - ((ty == 2'd0) ? AW'(0) : (ty == 2'd1) ? (h1 <<< 1) : h1);
    tdx  = bx - x2;
    tdy  = by - y2;
    ax   = (tx == 2'd1) ? tdx : (tdx <<< 1);
    bh   = (ty == 2'd1) ? tdy : (tdy <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b1;
      thr    <= asnap_pkg::THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        asnap_pkg::REG_ENABLE:    enable <= cfg_data[0];
        asnap_pkg::REG_THRESHOLD: thr    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op    <= asnap_pkg::op_t'(in_op);
      x2    <= ix2;
      y2    <= iy2;
      w1    <= iw;
      h1    <= ih;
      px[0] <= ix2;
      px[1] <= ix2 + (iw <<< 1);
      px[2] <= ix2 + iw;
      py[0] <= iy2;
      py[1] <= iy2 + (ih <<< 1);
      py[2] <= iy2 + ih;
      bestx <= asnap_pkg::BW'(AW'(thr) + asnap_pkg::THR_PAD);
      besty <= asnap_pkg::BW'(AW'(thr) + asnap_pkg::THR_PAD);
      bx    <= '0;
      by    <= '0;
      tx    <= '0;
      ty    <= '0;
      unique case (asnap_pkg::op_t'(in_op))
        asnap_pkg::OP_MOVE:   begin fa <= ix2;      fb <= iy2; end
        asnap_pkg::OP_RESIZE: begin fa <= iw <<< 1; fb <= ih <<< 1; end
        default:              begin fa <= '0;       fb <= '0; end
      endcase
    end
    if (cmd.srch) begin
      // strict compare keeps the earliest of equal distances
      if (dx < AW'(bestx)) begin
        bestx <= asnap_pkg::BW'(dx);
        bx    <= cx;
        tx    <= cmd.p;
      end
      if (dy < AW'(besty)) begin
        besty <= asnap_pkg::BW'(dy);
        by    <= cy;
        ty    <= cmd.p;
      end
    end
    if (cmd.snap) begin
      if (op == asnap_pkg::OP_MOVE) begin
        gpx[0] <= lx <<< 1;
        gpx[1] <= (lx <<< 1) + (w1 <<< 2);
        gpx[2] <= (lx <<< 1) + (w1 <<< 1);
        gpy[0] <= ty0 <<< 1;
        gpy[1] <= (ty0 <<< 1) + (h1 <<< 2);
        gpy[2] <= (ty0 <<< 1) + (h1 <<< 1);
        if (xs_n) fa <= lx;
        if (ys_n) fb <= ty0;
      end else begin
        gpx[0] <= x2 <<< 1;
        gpx[1] <= (x2 <<< 1) + (ax <<< 1);
        gpx[2] <= (x2 <<< 1) + ax;
        gpy[0] <= y2 <<< 1;
        gpy[1] <= (y2 <<< 1) + (bh <<< 1);
        gpy[2] <= (y2 <<< 1) + bh;
        if (xs_n) fa <= ax;
        if (ys_n) fb <= bh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xs      <= 1'b0;
      ys      <= 1'b0;
      dropped <= 1'b0;
      gcnt    <= '0;
    end else if (cmd.start) begin
      xs      <= 1'b0;
      ys      <= 1'b0;
      dropped <= 1'b0;
      gcnt    <= '0;
    end else begin
      if (cmd.snap) begin
        xs <= xs_n;
        ys <= ys_n;
      end
      if (cmd.gload) gcnt <= gcnt + GLW'(1);
      if (cmd.gdrop) dropped <= 1'b1;
    end
  end

  // add that found the table full
  always_ff @(posedge clk) begin
    if (rst) full_at_add <= 1'b0;
    else if (cmd.start) full_at_add <= (asnap_pkg::op_t'(in_op) == asnap_pkg::OP_ADD)
                                       && !cmd.wr;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (cmd.gload || cmd.fin) out_ch.valid <= 1'b1;
    else if (out_ch.ready) out_ch.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.gload) begin
      out_ch.item_kind      <= 1'b0;
      out_ch.guide_type     <= cmd.axis ? 3'(asnap_pkg::GT_TOP) + 3'(cmd.p)
                                        : 3'(asnap_pkg::GT_LEFT) + 3'(cmd.p);
      out_ch.guide_coord    <= asnap_pkg::sat_gc(cand);
      out_ch.out_a          <= '0;
      out_ch.out_b          <= '0;
      out_ch.x_snapped      <= 1'b0;
      out_ch.y_snapped      <= 1'b0;
      out_ch.guides_dropped <= 1'b0;
      out_ch.table_full     <= 1'b0;
      out_ch.last           <= 1'b0;
    end else if (cmd.fin) begin
      out_ch.item_kind      <= 1'b1;
      out_ch.guide_type     <= 3'(asnap_pkg::GT_LEFT);
      out_ch.guide_coord    <= '0;
      out_ch.out_a          <= asnap_pkg::sat_out(fa);
      out_ch.out_b          <= asnap_pkg::sat_out(fb);
      out_ch.x_snapped      <= xs;
      out_ch.y_snapped      <= ys;
      out_ch.guides_dropped <= dropped;
      out_ch.table_full     <= (op == asnap_pkg::OP_ADD) && full_at_add;
      out_ch.last           <= 1'b1;
    end
  end

  always_comb begin
    stat          = '0;
    stat.hit      = dg < asnap_pkg::GUIDE_TOL;
    stat.out_free = !out_ch.valid || out_ch.ready;
    stat.glim     = gcnt >= GLW'(GUIDE_LIMIT);
    stat.xs       = xs;
    stat.ys       = ys;
    stat.enable   = enable;
  end

  `ASN_ASSERT(a_gcnt_range, gcnt <= GLW'(GUIDE_LIMIT))
  `ASN_ASSERT(a_drop_after_limit, !dropped || gcnt == GLW'(GUIDE_LIMIT))
  `ASN_ASSERT_NEXT(a_load_valid, cmd.gload || cmd.fin, out_ch.valid)
endmodule

>>> hw/rtl/alignment_snap_search_core.sv
// Top level of the alignment snap search block: sequencer plus datapath.
// Depends on asnap_pkg, asnap_if, asnap_ctrl and asnap_dp.
//
//  channel  | dir | handshake          | content
//  in_ch    | in  | valid/ready        | operation, rect_x, rect_y, rect_w, rect_h
//  out_ch   | out | valid/ready        | guide items, then one final item (last)
//  cfg      | in  | cfg_we             | cfg_index 0 enable, 1 snap_threshold
//
// Clear and add go straight to the final item. A query first runs a nearest search
// of three candidates per stored rectangle against three points of the input
// (move) or two (resize), one candidate per cycle from the table RAM, then a snap
// step, then a guide scan for each snapped axis. Output backpressure stalls the
// guide scan; a result waiting in the output register does not block the next
// input. rst is synchronous and clears the count, state, scan counters, status
// flags and config registers (enable 1, threshold 320).
module alignment_snap_search_core #(
  parameter int MAX_RECTS   = asnap_pkg::MAX_RECTS_DEF,
  parameter int GUIDE_LIMIT = asnap_pkg::GUIDE_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  asnap_in_if.sink                      in_ch,
  asnap_out_if.source                   out_ch,
  input  logic                          cfg_we,
  input  logic [asnap_pkg::CFGIW-1:0]   cfg_index,
  input  logic [asnap_pkg::CFGW-1:0]    cfg_data
);
  localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

  asnap_pkg::ctrl_cmd_t cmd;
  asnap_pkg::dp_stat_t  stat;
  logic [IW-1:0] rd_addr, wr_addr;

  asnap_ctrl #(.MAX_RECTS(MAX_RECTS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.operation),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr)
  );

  asnap_dp #(.MAX_RECTS(MAX_RECTS), .GUIDE_LIMIT(GUIDE_LIMIT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_op     (in_ch.operation),
    .in_x      (in_ch.rect_x),
    .in_y      (in_ch.rect_y),
    .in_w      (in_ch.rect_w),
    .in_h      (in_ch.rect_h),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ch    (out_ch)
  );
endmodule
